// ===== rtl/core/bsi_pkg.sv =====
// Shared constants and codes for the broadcast source index block.
package bsi_pkg;

  localparam int MAX_RANK_DEF   = 4;
  localparam int DIM_BITS_DEF   = 16;
  localparam int INDEX_BITS_DEF = 32;

  localparam int OUT_INDEX_W = 32;
  localparam int SRC_INDEX_W = 32;
  localparam int STATUS_W    = 2;
  localparam int RANK_W      = 3;
  localparam int SHAPE_W     = 64;
  localparam int COUNT_W     = 32;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_OUT_RANK  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SRC_RANK  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_OUT_SHAPE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SRC_SHAPE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_IN_COUNT  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_OUT_COUNT = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD   = 2'd3;

  // Address mode picked at entry
  localparam logic [1:0] MD_ONE  = 2'd0;
  localparam logic [1:0] MD_SAME = 2'd1;
  localparam logic [1:0] MD_AXIS = 2'd2;
  localparam logic [1:0] MD_MOD  = 2'd3;

endpackage

// ===== rtl/core/bsi_if.sv =====
// Request and response channel interfaces.
interface bsi_req_if import bsi_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OUT_INDEX_W-1:0] out_index;
  modport source (output valid, output out_index, input ready);
  modport sink (input valid, input out_index, output ready);
endinterface

interface bsi_rsp_if import bsi_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SRC_INDEX_W-1:0] src_index;
  logic [STATUS_W-1:0]    status;
  modport source (output valid, output src_index, output status, input ready);
  modport sink (input valid, input src_index, input status, output ready);
endinterface

// ===== rtl/core/bsi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module bsi_div import bsi_pkg::*; #(
  parameter int DW = 32,
  parameter int VW = 32,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder,
  output logic [SW-1:0] side_out
);

  logic          v    [DW+1];
  logic [DW-1:0] q    [DW+1];
  logic [VW-1:0] r    [DW+1];
  logic [SW-1:0] side [DW+1];

  assign v[0]    = in_valid;
  assign q[0]    = dividend;
  assign r[0]    = '0;
  assign side[0] = side_in;

  for (genvar i = 0; i < DW; i++) begin : g_stage
    logic [VW:0] t;
    logic [VW:0] t_sub;
    logic        ge;

    always_comb begin
      t     = {r[i], q[i][DW-1]};
      ge    = t >= {1'b0, divisor};
      t_sub = t - {1'b0, divisor};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q[i+1]    <= {q[i][DW-2:0], ge};
        r[i+1]    <= ge ? t_sub[VW-1:0] : t[VW-1:0];
        side[i+1] <= side[i];
      end
    end
  end

  assign out_valid = v[DW];
  assign quotient  = q[DW];
  assign remainder = r[DW];
  assign side_out  = side[DW];

endmodule

// ===== rtl/core/bsi_axis.sv =====
// One axis of the mixed-radix walk: divide by the output size, then scale and add.
module bsi_axis import bsi_pkg::*; #(
  parameter int IW       = 32,
  parameter int DIM_BITS = 16,
  parameter int SW       = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic                active,
  input  logic [IW-1:0]       rem_in,
  input  logic [IW-1:0]       acc_in,
  input  logic [IW-1:0]       stride_in,
  input  logic [DIM_BITS-1:0] od,
  input  logic [DIM_BITS-1:0] sd,
  input  logic [SW-1:0]       side_in,
  output logic                out_valid,
  output logic [IW-1:0]       rem_out,
  output logic [IW-1:0]       acc_out,
  output logic [IW-1:0]       stride_out,
  output logic [SW-1:0]       side_out
);

  localparam int CW = 1 + 3*IW + SW;
  localparam int PW = IW + DIM_BITS;

  logic                d_valid;
  logic [IW-1:0]       d_quot;
  logic [DIM_BITS-1:0] d_rem;
  logic [CW-1:0]       d_side;

  logic                c_active;
  logic [IW-1:0]       c_acc;
  logic [IW-1:0]       c_stride;
  logic [IW-1:0]       c_rem;
  logic [SW-1:0]       c_side;
  logic [PW-1:0]       prod_c;
  logic [PW-1:0]       prod_s;
  logic [IW-1:0]       acc_next;
  logic [IW-1:0]       stride_next;
  logic [IW-1:0]       rem_next;

  bsi_div #(.DW(IW), .VW(DIM_BITS), .SW(CW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .dividend  (rem_in),
    .divisor   (od),
    .side_in   ({active, acc_in, stride_in, rem_in, side_in}),
    .out_valid (d_valid),
    .quotient  (d_quot),
    .remainder (d_rem),
    .side_out  (d_side)
  );

  always_comb begin
    {c_active, c_acc, c_stride, c_rem, c_side} = d_side;
    prod_c = PW'(d_rem) * PW'(c_stride);
    prod_s = PW'(c_stride) * PW'(sd);
    if (c_active) begin
      // size-1 source axes repeat, so they add no offset
      acc_next    = (sd != DIM_BITS'(1)) ? c_acc + prod_c[IW-1:0] : c_acc;
      stride_next = prod_s[IW-1:0];
      rem_next    = d_quot;
    end else begin
      acc_next    = c_acc;
      stride_next = c_stride;
      rem_next    = c_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out    <= rem_next;
      acc_out    <= acc_next;
      stride_out <= stride_next;
      side_out   <= c_side;
    end
  end

endmodule

// ===== rtl/core/broadcast_source_index.sv =====
// Broadcast source index: maps a flat output index of a tensor broadcast to
// the flat source index. One request is taken every cycle unless the
// response is stalled; a stall freezes the whole pipeline and no request
// is lost. Requests pass the entry register, a divider pipeline for the
// index modulo the source count, then one divider pipeline per axis for
// the mixed-radix walk. Configuration is to be written through
// cfg_we/cfg_index/cfg_data while idle; the block does not enforce this.
module broadcast_source_index import bsi_pkg::*; #(
  parameter int MAX_RANK   = MAX_RANK_DEF,
  parameter int DIM_BITS   = DIM_BITS_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  bsi_req_if.sink                req,
  bsi_rsp_if.source              rsp
);

  localparam int IW  = INDEX_BITS;
  localparam int MSW = STATUS_W + 2 + IW;
  localparam int ASW = STATUS_W + 1 + IW;

  logic [RANK_W-1:0]  out_rank;
  logic [RANK_W-1:0]  src_rank;
  logic [SHAPE_W-1:0] out_shape;
  logic [SHAPE_W-1:0] src_shape;
  logic [COUNT_W-1:0] in_count;
  logic [COUNT_W-1:0] out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_rank  <= '0;
      src_rank  <= '0;
      out_shape <= '0;
      src_shape <= '0;
      in_count  <= COUNT_W'(1);
      out_count <= COUNT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OUT_RANK:  out_rank  <= cfg_data[RANK_W-1:0];
        CFG_SRC_RANK:  src_rank  <= cfg_data[RANK_W-1:0];
        CFG_OUT_SHAPE: out_shape <= cfg_data[SHAPE_W-1:0];
        CFG_SRC_SHAPE: src_shape <= cfg_data[SHAPE_W-1:0];
        CFG_IN_COUNT:  in_count  <= cfg_data[COUNT_W-1:0];
        CFG_OUT_COUNT: out_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // axis sizes; axes lying past the shape register read as zero
  logic [DIM_BITS-1:0] od [MAX_RANK];
  logic [DIM_BITS-1:0] sd [MAX_RANK];
  logic [127:0]        out_shape_x;
  logic [127:0]        src_shape_x;

  assign out_shape_x = {64'd0, out_shape};
  assign src_shape_x = {64'd0, src_shape};

  for (genvar a = 0; a < MAX_RANK; a++) begin : g_dim
    localparam int POS = a * DIM_BITS;
    if (POS >= SHAPE_W) begin : g_out
      assign od[a] = '0;
      assign sd[a] = '0;
    end else begin : g_in
      assign od[a] = out_shape_x[POS +: DIM_BITS];
      assign sd[a] = src_shape_x[POS +: DIM_BITS];
    end
  end

  logic [3:0] rank_sat;
  assign rank_sat = (4'(out_rank) > 4'(MAX_RANK)) ? 4'(MAX_RANK) : 4'(out_rank);

  logic en;
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  // entry register
  logic                   e_valid;
  logic [OUT_INDEX_W-1:0] e_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && req.valid) begin
      e_idx <= req.out_index;
    end
  end

  // mode and status decode
  logic [IW-1:0]       idx_iw;
  logic [63:0]         idx_w;
  logic                axis_ok;
  logic                size_err;
  logic [1:0]          mode;
  logic [STATUS_W-1:0] e_status;

  always_comb begin
    idx_iw   = IW'(e_idx);
    idx_w    = 64'(idx_iw);
    axis_ok  = (out_rank != '0) && (src_rank == out_rank);
    size_err = 1'b0;
    for (int a = 0; a < MAX_RANK; a++) begin
      if ((4'(a) < rank_sat) && ((od[a] == '0) || (sd[a] == '0))) begin
        size_err = 1'b1;
      end
    end
    if (in_count == COUNT_W'(1)) begin
      mode = MD_ONE;
    end else if (in_count == out_count) begin
      mode = MD_SAME;
    end else if (axis_ok) begin
      mode = MD_AXIS;
    end else begin
      mode = MD_MOD;
    end
    if ((in_count == '0) || (out_count == '0)) begin
      e_status = ST_ZERO;
    end else if (idx_w >= 64'(out_count)) begin
      e_status = ST_RANGE;
    end else if ((mode == MD_AXIS) && size_err) begin
      e_status = ST_ZERO;
    end else begin
      e_status = ST_OK;
    end
  end

  // index modulo source count
  logic                m_valid;
  logic [COUNT_W-1:0]  m_rem;
  logic [MSW-1:0]      m_side;
  logic [STATUS_W-1:0] m_status;
  logic [1:0]          m_mode;
  logic [IW-1:0]       m_idx;
  logic [IW-1:0]       m_base;

  bsi_div #(.DW(IW), .VW(COUNT_W), .SW(MSW)) u_mod (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (e_valid),
    .dividend  (idx_iw),
    .divisor   (in_count),
    .side_in   ({e_status, mode, idx_iw}),
    .out_valid (m_valid),
    .quotient  (),
    .remainder (m_rem),
    .side_out  (m_side)
  );

  always_comb begin
    {m_status, m_mode, m_idx} = m_side;
    unique case (m_mode)
      MD_ONE:  m_base = '0;
      MD_SAME: m_base = m_idx;
      MD_MOD:  m_base = IW'(m_rem);
      default: m_base = '0;
    endcase
  end

  // axis walk, last axis first
  logic           ax_valid  [MAX_RANK+1];
  logic [IW-1:0]  ax_rem    [MAX_RANK+1];
  logic [IW-1:0]  ax_acc    [MAX_RANK+1];
  logic [IW-1:0]  ax_stride [MAX_RANK+1];
  logic [ASW-1:0] ax_side   [MAX_RANK+1];

  assign ax_valid[0]  = m_valid;
  assign ax_rem[0]    = m_idx;
  assign ax_acc[0]    = '0;
  assign ax_stride[0] = IW'(1);
  assign ax_side[0]   = {m_status, (m_mode == MD_AXIS) && (m_status == ST_OK), m_base};

  for (genvar j = 0; j < MAX_RANK; j++) begin : g_axis
    localparam int AX = MAX_RANK - 1 - j;
    logic act;
    assign act = ax_side[j][IW] && (4'(AX) < rank_sat);

    bsi_axis #(.IW(IW), .DIM_BITS(DIM_BITS), .SW(ASW)) u_axis (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .in_valid   (ax_valid[j]),
      .active     (act),
      .rem_in     (ax_rem[j]),
      .acc_in     (ax_acc[j]),
      .stride_in  (ax_stride[j]),
      .od         (od[AX]),
      .sd         (sd[AX]),
      .side_in    (ax_side[j]),
      .out_valid  (ax_valid[j+1]),
      .rem_out    (ax_rem[j+1]),
      .acc_out    (ax_acc[j+1]),
      .stride_out (ax_stride[j+1]),
      .side_out   (ax_side[j+1])
    );
  end

  logic [STATUS_W-1:0] f_status;
  logic                f_axis;
  logic [IW-1:0]       f_base;
  logic [IW-1:0]       f_res;

  always_comb begin
    {f_status, f_axis, f_base} = ax_side[MAX_RANK];
    if (f_status != ST_OK) begin
      f_res = '0;
    end else if (f_axis) begin
      f_res = ax_acc[MAX_RANK];
    end else begin
      f_res = f_base;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= ax_valid[MAX_RANK];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.src_index <= SRC_INDEX_W'(f_res);
      rsp.status    <= f_status;
    end
  end

endmodule

// ===== rtl/core/bsi_checker.sv =====
// Port-level checks for the broadcast source index block, bound to the top.
module bsi_checker import bsi_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   req_valid,
  input logic                   req_ready,
  input logic                   rsp_valid,
  input logic                   rsp_ready,
  input logic [SRC_INDEX_W-1:0] src_index,
  input logic [STATUS_W-1:0]    status
);

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status != ST_BAD)
    else $error("status code out of range");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ST_OK) |-> src_index == '0)
    else $error("nonzero index with error status");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("request taken while response stalled");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(src_index) && $stable(status))
    else $error("stalled response changed");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("not ready with empty output");

endmodule

bind broadcast_source_index bsi_checker u_bsi_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .src_index (rsp.src_index),
  .status    (rsp.status)
);
